// ----- hdl/bdhe_pkg.sv -----
// Shared types and constants for the button debounce and hold event block.
package bdhe_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] RegDebounceTime = 2'd0;
  localparam logic [CfgIndexW-1:0] RegHoldTime = 2'd1;

  localparam logic [CfgW-1:0] DebounceTimeReset = 16'd35;
  localparam logic [CfgW-1:0] HoldTimeReset = 16'd600;

  typedef enum logic [1:0] {
    EV_DOWN  = 2'd0,
    EV_HOLD  = 2'd1,
    EV_UP    = 2'd2,
    EV_SHORT = 2'd3
  } event_kind_t;

  // Results of one sample: the first event, and for an up with no hold,
  // a short press that follows with the same duration.
  typedef struct packed {
    event_kind_t      kind;
    logic [TimeW-1:0] held;
    logic             two;
  } run_t;

endpackage

// ----- hdl/bdhe_if.sv -----
// Channel interfaces: raw samples in, button events out.
interface bdhe_in_if;
  import bdhe_pkg::*;
  logic             valid;
  logic             ready;
  logic             pressed_level;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, output pressed_level, output now_ms, input ready);
  modport sink (input valid, input pressed_level, input now_ms, output ready);
endinterface

interface bdhe_out_if;
  import bdhe_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       event_kind;
  logic [TimeW-1:0] held_ms;
  logic             last_of_run;

  modport source (output valid, output event_kind, output held_ms, output last_of_run,
                  input ready);
  modport sink (input valid, input event_kind, input held_ms, input last_of_run,
                output ready);
endinterface

// ----- hdl/bdhe_evt_queue.sv -----
// Two-entry queue of per-sample event runs, sent out one event per beat.
module bdhe_evt_queue
  import bdhe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_run,
  output logic push_ready,
  bdhe_out_if.source events
);

  run_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       sub;

  run_t       head;
  logic       last;
  logic       fire;
  logic       pop;
  logic       do_push;

  assign head       = mem[rd_ptr];
  assign last       = sub | ~head.two;
  assign push_ready = (count != 2'd2);
  assign do_push    = push & push_ready;
  assign fire       = events.valid & events.ready;
  assign pop        = fire & last;

  assign events.valid       = (count != 2'd0);
  assign events.event_kind  = sub ? EV_SHORT : head.kind;
  assign events.held_ms     = head.held;
  assign events.last_of_run = last;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      sub    <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      // advance to the trailing short beat, drop back after the last one
      if (fire) begin
        sub <= ~last;
      end
      case ({do_push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("event queue count out of range");

  a_sub_needs_pair: assert property (@(posedge clk) disable iff (rst)
    sub |-> (count != 2'd0) && head.two)
    else $error("second beat without a two-event run");

  a_sub_holds: assert property (@(posedge clk) disable iff (rst)
    sub && !events.ready |=> sub && $stable(rd_ptr))
    else $error("stalled second beat moved");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    do_push && !pop |=> count == $past(count) + 2'd1)
    else $error("push not counted");

endmodule

// ----- hdl/button_debounce_hold_events_core.sv -----
// Top level: debounce raw button samples and emit down, hold, up and short events.
//
//   channel   dir  beat payload
//   samples   in   pressed_level, now_ms
//   events    out  event_kind, held_ms, last_of_run
//   cfg_*     in   write enable, register index, 16-bit data
//
// One sample is taken per cycle while the run queue has room; its state update and
// events are formed in the accept cycle and queued in a two-entry run queue.
// A sample with two events (up then short) holds the output for two beats.
// samples.ready drops only while both queue entries are occupied.
// rst is synchronous: state clears, registers return to 35 and 600 ms.
module button_debounce_hold_events_core
  import bdhe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgW-1:0]      cfg_data,
  bdhe_in_if.sink              samples,
  bdhe_out_if.source           events
);

  logic [CfgW-1:0]  debounce_time;
  logic [CfgW-1:0]  hold_time;

  logic             previous_sample;
  logic [TimeW-1:0] change_time;
  logic             stable_level;
  logic             hold_reported;
  logic [TimeW-1:0] press_time;

  logic             accept;
  logic             push_ready;
  logic             level;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] change_time_next;
  logic             settled;
  logic [TimeW-1:0] held;
  logic             push;
  run_t             push_run;
  logic             stable_level_next;
  logic             hold_reported_next;
  logic [TimeW-1:0] press_time_next;

  assign level  = samples.pressed_level;
  assign now    = samples.now_ms;
  assign accept = samples.valid & push_ready;
  assign samples.ready = push_ready;

  always_comb begin
    change_time_next   = (level != previous_sample) ? now : change_time;
    settled            = (now - change_time_next) >= {{(TimeW-CfgW){1'b0}}, debounce_time};
    held               = now - press_time;
    push               = 1'b0;
    push_run.kind      = EV_DOWN;
    push_run.held      = held;
    push_run.two       = 1'b0;
    stable_level_next  = stable_level;
    hold_reported_next = hold_reported;
    press_time_next    = press_time;
    if (settled) begin
      if (level == stable_level) begin
        if (stable_level && !hold_reported &&
            held >= {{(TimeW-CfgW){1'b0}}, hold_time}) begin
          hold_reported_next = 1'b1;
          push               = 1'b1;
          push_run.kind      = EV_HOLD;
        end
      end else begin
        stable_level_next = level;
        push              = 1'b1;
        if (level) begin
          press_time_next    = now;
          hold_reported_next = 1'b0;
          push_run.kind      = EV_DOWN;
          push_run.held      = '0;
        end else begin
          push_run.kind = EV_UP;
          push_run.two  = ~hold_reported;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DebounceTimeReset;
      hold_time     <= HoldTimeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDebounceTime: debounce_time <= cfg_data;
        RegHoldTime:     hold_time     <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= 1'b0;
      change_time     <= '0;
      stable_level    <= 1'b0;
      hold_reported   <= 1'b0;
      press_time      <= '0;
    end else if (accept) begin
      previous_sample <= level;
      change_time     <= change_time_next;
      stable_level    <= stable_level_next;
      hold_reported   <= hold_reported_next;
      press_time      <= press_time_next;
    end
  end

  bdhe_evt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept & push),
    .push_run   (push_run),
    .push_ready (push_ready),
    .events     (events)
  );

endmodule

// ----- tb/sv/bdhe_event_checker.sv -----
// Event checker: watches samples, config writes and events, predicts and compares.
module bdhe_event_checker
  import bdhe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgW-1:0]      cfg_data,
  bdhe_in_if                   samples,
  bdhe_out_if                  events,
  output int                   mismatches,
  output int                   events_due
);

  typedef struct {
    event_kind_t      kind;
    logic [TimeW-1:0] held;
    logic             last;
  } button_event_t;

  button_event_t due_events[$];

  // predicted block state
  logic [CfgW-1:0]  debounce_ms;
  logic [CfgW-1:0]  hold_ms;
  logic             raw_level;
  logic             settled_level;
  logic             hold_sent;
  logic [TimeW-1:0] change_ms;
  logic [TimeW-1:0] press_ms;

  task automatic queue_event(input event_kind_t kind, input logic [TimeW-1:0] held,
                             input logic last);
    button_event_t ev;
    ev.kind = kind;
    ev.held = held;
    ev.last = last;
    due_events.push_back(ev);
  endtask

  task automatic predict_events(input logic level, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] since_change;
    logic [TimeW-1:0] held;
    if (level != raw_level) begin
      raw_level = level;
      change_ms = now;
    end
    since_change = now - change_ms;
    // still bouncing: only the raw tracking moves
    if (since_change < TimeW'(debounce_ms)) return;
    held = now - press_ms;
    if (level == settled_level) begin
      if (settled_level && !hold_sent && held >= TimeW'(hold_ms)) begin
        hold_sent = 1'b1;
        queue_event(EV_HOLD, held, 1'b1);
      end
    end else begin
      settled_level = level;
      if (level) begin
        press_ms = now;
        hold_sent = 1'b0;
        queue_event(EV_DOWN, '0, 1'b1);
      end else if (hold_sent) begin
        queue_event(EV_UP, held, 1'b1);
      end else begin
        queue_event(EV_UP, held, 1'b0);
        queue_event(EV_SHORT, held, 1'b1);
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    button_event_t want;
    if (rst) begin
      debounce_ms = DebounceTimeReset;
      hold_ms = HoldTimeReset;
      raw_level = 1'b0;
      settled_level = 1'b0;
      hold_sent = 1'b0;
      change_ms = '0;
      press_ms = '0;
      mismatches = 0;
      due_events.delete();
    end else begin
      // compare the event beat before predicting: a sample cannot answer on its own edge
      if (events.valid && events.ready) begin
        if (due_events.size() == 0) begin
          note_mismatch($sformatf("unexpected event: kind %0d held %0d last %0d",
                                  events.event_kind, events.held_ms, events.last_of_run));
        end else begin
          want = due_events.pop_front();
          if (events.event_kind !== want.kind || events.held_ms !== want.held ||
              events.last_of_run !== want.last) begin
            note_mismatch($sformatf(
                "event mismatch: expected kind %0d held %0d last %0d, got kind %0d held %0d last %0d",
                want.kind, want.held, want.last,
                events.event_kind, events.held_ms, events.last_of_run));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          RegDebounceTime: debounce_ms = cfg_data;
          RegHoldTime: hold_ms = cfg_data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) predict_events(samples.pressed_level, samples.now_ms);
    end
    events_due = due_events.size();
  end

endmodule

// ----- tb/sv/tb_button_debounce_hold_events_core.sv -----
// Testbench top: drives samples and config writes, stalls events, gives the verdict.
module tb_button_debounce_hold_events_core;
  import bdhe_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles = 8;
  localparam int PhaseItems = 100;

  // indexes with no register behind them
  localparam logic [CfgIndexW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIndexW-1:0] RegSpareB = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgW-1:0]      cfg_data;

  bdhe_in_if  samples ();
  bdhe_out_if events ();

  int event_fails;
  int events_due;

  logic [TimeW-1:0] clock_ms;
  logic [CfgW-1:0]  deb_cfg;
  logic [CfgW-1:0]  hold_cfg;
  int               gap_pct;
  int               stall_pct;
  int               sample_count;
  int               idle_cycles;
  bit               hold_off_armed;
  bit               hold_off_done;

  button_debounce_hold_events_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .events    (events)
  );

  bdhe_event_checker event_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samples    (samples),
    .events     (events),
    .mismatches (event_fails),
    .events_due (events_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one sample and hold it until the beat is taken.
  task automatic send_sample(input logic level, input logic [TimeW-1:0] now);
    while ($urandom_range(99) < gap_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.pressed_level <= level;
    samples.now_ms <= now;
    do @(posedge clk); while (!samples.ready);
    sample_count++;
  endtask

  task automatic step_sample(input logic level, input logic [TimeW-1:0] step);
    clock_ms = clock_ms + step;
    send_sample(level, clock_ms);
  endtask

  // Wait for every due event, then let the pipeline drain.
  task automatic quiesce();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] hold);
    cfg_we <= 1'b1;
    cfg_index <= RegDebounceTime;
    cfg_data <= deb;
    @(posedge clk);
    cfg_index <= RegHoldTime;
    cfg_data <= hold;
    @(posedge clk);
    cfg_index <= $urandom_range(0, 1) ? RegSpareA : RegSpareB;
    cfg_data <= CfgW'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    deb_cfg = deb;
    hold_cfg = hold;
  endtask

  // Optional chatter, then a run of one level that outlasts the debounce window.
  task automatic bounce_then_settle(input logic level);
    int chatter;
    chatter = $urandom_range(0, 3);
    repeat (chatter) step_sample(1'($urandom_range(0, 1)), $urandom_range(0, deb_cfg));
    repeat ($urandom_range(1, 3)) step_sample(level, $urandom_range(0, deb_cfg / 2));
    step_sample(level, deb_cfg + $urandom_range(0, 3));
  endtask

  task automatic press_episode();
    bounce_then_settle(1'b1);
    case ($urandom_range(0, 2))
      0: step_sample(1'b1, hold_cfg + $urandom_range(0, 20));
      1: begin
        if (hold_cfg > 0) step_sample(1'b1, $urandom_range(0, hold_cfg - 1));
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 2)) step_sample(1'b1, $urandom_range(0, deb_cfg));
    bounce_then_settle(1'b0);
    repeat ($urandom_range(0, 2)) step_sample(1'b0, $urandom_range(0, deb_cfg));
  endtask

  task automatic run_phase(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] hold,
                           input int gap, input int stall, input bit pressure);
    int start_count;
    int pick;
    quiesce();
    set_config(deb, hold);
    gap_pct = gap;
    stall_pct = stall;
    hold_off_armed = pressure;
    start_count = sample_count;
    while (sample_count - start_count < PhaseItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // jump anywhere in time, forward or back
        clock_ms = $urandom();
        send_sample(1'($urandom_range(0, 1)), clock_ms);
      end else if (pick < 12) begin
        // land the episode across the 32-bit wrap
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * deb_cfg + 40);
        press_episode();
      end else if (pick < 18) begin
        step_sample(1'($urandom_range(0, 1)), $urandom_range(0, deb_cfg));
      end else begin
        press_episode();
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= RegDebounceTime;
    cfg_data <= '0;
    samples.valid <= 1'b0;
    samples.pressed_level <= 1'b0;
    samples.now_ms <= '0;
    gap_pct = 0;
    stall_pct = 0;
    clock_ms = '0;
    sample_count = 0;
    hold_off_armed = 1'b0;
    deb_cfg = DebounceTimeReset;
    hold_cfg = HoldTimeReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: debounce boundary, hold boundary, bounce back, release after hold
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd35);
    send_sample(1'b1, 32'd634);
    send_sample(1'b1, 32'd635);
    send_sample(1'b1, 32'd700);
    send_sample(1'b0, 32'd800);
    send_sample(1'b1, 32'd810);
    send_sample(1'b1, 32'd845);
    send_sample(1'b0, 32'd900);
    send_sample(1'b0, 32'd935);
    // short press, one ms short of the window first
    send_sample(1'b1, 32'd1000);
    send_sample(1'b1, 32'd1035);
    send_sample(1'b0, 32'd1100);
    send_sample(1'b0, 32'd1134);
    send_sample(1'b0, 32'd1135);
    // time going backwards, then the wrap
    send_sample(1'b1, 32'd500);
    send_sample(1'b1, 32'd600);
    send_sample(1'b1, 32'd200);
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b0, 32'h0000_0013);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0022);
    // zero debounce and zero hold
    quiesce();
    set_config('0, '0);
    send_sample(1'b0, 32'd40);
    send_sample(1'b1, 32'd50);
    send_sample(1'b1, 32'd50);
    send_sample(1'b0, 32'd51);
    send_sample(1'b1, 32'd60);
    send_sample(1'b0, 32'd60);
    clock_ms = 32'd60;

    run_phase(DebounceTimeReset, HoldTimeReset, 0, 0, 1'b0);
    run_phase('0, '0, 71, 0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 0, 71, 1'b0);
    run_phase(16'd1, 16'd1, 29, 29, 1'b0);
    run_phase(CfgW'($urandom_range(0, 100)), CfgW'($urandom_range(0, 1000)), 0, 0, 1'b1);
    run_phase('0, 16'hFFFF, 71, 0, 1'b0);
    run_phase(16'hFFFF, '0, 0, 71, 1'b0);
    run_phase(CfgW'($urandom_range(0, 60)), CfgW'($urandom_range(0, 300)), 29, 29, 1'b0);
    run_phase(CfgW'($urandom_range(0, 16'hFFFF)), CfgW'($urandom_range(0, 16'hFFFF)),
              0, 0, 1'b0);
    quiesce();

    if (event_fails == 0) begin
      $display("button_debounce_hold_events_core regression: pass");
    end else begin
      $display("button_debounce_hold_events_core regression: fail");
    end
    $finish;
  end

  // Event receiver: random stalls, plus one long hold-off when armed.
  initial begin
    hold_off_done = 1'b0;
    events.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_armed && !hold_off_done) begin
        repeat (HoldOffCycles) begin
          events.ready <= 1'b0;
          @(posedge clk);
        end
        hold_off_done = 1'b1;
      end
      events.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (events.valid && events.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("button_debounce_hold_events_core regression: fail");
        $finish;
      end
    end
  end

endmodule
